[rtl/core/hsn_pkg.sv]
// Shared constants for the height-to-normal block.
// No dependencies.
package hsn_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 15;
  localparam int STEP_BITS         = 16;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd1;

endpackage

[rtl/core/height_to_surface_normal.sv]
// Surface normal from three height samples, forward differences, Q1.F output.
// Depends on hsn_pkg.
//
// Usage
//   cfg channel  : cfg_valid_i/cfg_ready_o/cfg_data_i write the step length. Ready is
//                  always high. A step of zero is taken as one. Reset value is one.
//   s_axis       : one request per pixel carrying height_here, height_next_x and
//                  height_next_y. One request can be taken every clock unless m_axis stalls.
//   m_axis       : one normal per request, in request order.
// Throughput: one request per clock while the output is not stalled.
// Cost is set by the pipeline: an input register, a squaring stage, a sum stage,
// 2F+3 restoring division stages (one quotient bit each, three lanes sharing the
// divisor), F+2 square-root stages (one result bit each) and an output register.
// Method: T = floor(4*m^2*2^2F / S), then q = (isqrt(T)+1)/2, saturated at 2^F-1.
// Reset: all valid bits clear, the step register returns to one; nothing is output
//   until a new request arrives.
// Stall: when m_axis_tready is low with a result waiting, the whole pipe holds and
//   s_axis_tready drops in the same cycle; nothing is lost or repeated. While the
//   output register is empty or being taken, the pipe advances every cycle.
module height_to_surface_normal #(
  parameter int SAMPLE_BITS   = hsn_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = hsn_pkg::FRACTION_BITS_DEF,
  localparam int IN_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * FRACTION_BITS + 2 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hsn_pkg::STEP_BITS-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // height_here, height_next_x, height_next_y (SAMPLE_BITS each), zero pad
  input  logic [IN_W-1:0]               s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // normal_x (F+1), normal_y (F), normal_z (F+1), zero pad
  output logic [OUT_W-1:0]              m_axis_tdata
);

  localparam int SB  = SAMPLE_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int MW  = (SB > hsn_pkg::STEP_BITS) ? SB : hsn_pkg::STEP_BITS;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;     // sum of three squares
  localparam int QW  = 2 * F + 3;   // quotient T <= 2^(2F+2)
  localparam int RW  = F + 2;       // isqrt(T) <= 2^(F+1)

  logic en;
  logic [hsn_pkg::STEP_BITS-1:0] step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= hsn_pkg::STEP_RESET;
    end else if (cfg_valid_i) begin
      step_q <= cfg_data_i;
    end
  end

  // ---------------- stage 0: differences and magnitudes
  logic [SB-1:0] h, hx, hy;
  logic          xpos, ypos;
  logic [MW-1:0] mag_d [0:2];
  logic [MW-1:0] mag_q [0:2];
  logic [1:0]    pos0_q, pos1_q;
  logic          v0_q, v1_q;

  assign h    = s_axis_tdata[SB-1:0];
  assign hx   = s_axis_tdata[2*SB-1:SB];
  assign hy   = s_axis_tdata[3*SB-1:2*SB];
  assign xpos = hx > h;
  assign ypos = hy > h;

  always_comb begin
    mag_d[0] = MW'(xpos ? hx - h : h - hx);
    mag_d[1] = (step_q == '0) ? MW'(1) : MW'(step_q);
    mag_d[2] = MW'(ypos ? hy - h : h - hy);
  end

  // ---------------- stage 1: squares
  logic [SQW-1:0] sq_q [0:2];

  // ---------------- division pipe, index 0 is the sum stage
  logic [QW:0]    dv_q;
  logic [SW-1:0]  rem_q  [0:QW][0:2];
  logic [QW-1:0]  quot_q [1:QW][0:2];
  logic [SW-1:0]  sum_q  [0:QW];
  logic [1:0]     dpos_q [0:QW];
  logic [2:0]     lb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      dv_q[0]  <= 1'b0;
    end else if (en) begin
      v0_q     <= s_axis_tvalid;
      v1_q     <= v0_q;
      dv_q[0]  <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        mag_q[c]    <= mag_d[c];
        sq_q[c]     <= SQW'(mag_q[c]) * SQW'(mag_q[c]);
        rem_q[0][c] <= SW'(sq_q[c] >> 1);
        lb_q[c]     <= sq_q[c][0];
      end
      pos0_q    <= {ypos, xpos};
      pos1_q    <= pos0_q;
      dpos_q[0] <= pos1_q;
      sum_q[0]  <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [SW:0]   trial [0:2];
    logic [2:0]    ge;
    logic [QW-1:0] qprev [0:2];
    for (genvar c = 0; c < 3; c++) begin : g_lane
      assign trial[c] = {rem_q[k-1][c], (k == 1) ? lb_q[c] : 1'b0};
      assign ge[c]    = trial[c] >= {1'b0, sum_q[k-1]};
      if (k == 1) begin : g_first
        assign qprev[c] = '0;
      end else begin : g_next
        assign qprev[c] = quot_q[k-1][c];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          rem_q[k][c]  <= ge[c] ? SW'(trial[c] - {1'b0, sum_q[k-1]}) : SW'(trial[c]);
          quot_q[k][c] <= {qprev[c][QW-2:0], ge[c]};
        end
        sum_q[k]  <= sum_q[k-1];
        dpos_q[k] <= dpos_q[k-1];
      end
    end
  end

  // ---------------- square root pipe, fed by the last division stage
  logic [RW:1]   sv_q;
  logic [RW-1:0] root_q [1:RW][0:2];
  logic [QW:0]   rsq_q  [1:RW][0:2];
  logic [QW-1:0] rt_q   [1:RW][0:2];
  logic [1:0]    spos_q [1:RW];

  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    localparam int B = RW - j;
    logic [RW-1:0] root_p [0:2];
    logic [QW:0]   rsq_p  [0:2];
    logic [QW-1:0] rt_p   [0:2];
    logic          v_p;
    logic [1:0]    pos_p;
    logic [QW:0]   csq  [0:2];
    logic [2:0]    take;

    if (j == 1) begin : g_head
      assign v_p   = dv_q[QW];
      assign pos_p = dpos_q[QW];
      for (genvar c = 0; c < 3; c++) begin : g_lane
        assign root_p[c] = '0;
        assign rsq_p[c]  = '0;
        assign rt_p[c]   = quot_q[QW][c];
      end
    end else begin : g_body
      assign v_p   = sv_q[j-1];
      assign pos_p = spos_q[j-1];
      for (genvar c = 0; c < 3; c++) begin : g_lane
        assign root_p[c] = root_q[j-1][c];
        assign rsq_p[c]  = rsq_q[j-1][c];
        assign rt_p[c]   = rt_q[j-1][c];
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
      assign csq[c]  = rsq_p[c] + ((QW+1)'(root_p[c]) << (B + 1))
                       + ((QW+1)'(1) << (2 * B));
      assign take[c] = csq[c] <= (QW+1)'(rt_p[c]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j] <= 1'b0;
      end else if (en) begin
        sv_q[j] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          root_q[j][c] <= take[c] ? (root_p[c] | (RW'(1) << B)) : root_p[c];
          rsq_q[j][c]  <= take[c] ? csq[c] : rsq_p[c];
          rt_q[j][c]   <= rt_p[c];
        end
        spos_q[j] <= pos_p;
      end
    end
  end

  // ---------------- output stage: halve with rounding, saturate, sign
  logic [RW-1:0] qv  [0:2];
  logic [F-1:0]  mag [0:2];
  logic [F:0]    nx_d, nz_d;
  logic [F:0]    nx_q, nz_q;
  logic [F-1:0]  ny_q;
  logic          m_valid_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qv[c]  = RW'(((RW+1)'(root_q[RW][c]) + (RW+1)'(1)) >> 1);
      mag[c] = (qv[c] > RW'({F{1'b1}})) ? {F{1'b1}} : F'(qv[c]);
    end
    nx_d = spos_q[RW][0] ? -(F+1)'(mag[0]) : (F+1)'(mag[0]);
    nz_d = spos_q[RW][1] ? -(F+1)'(mag[2]) : (F+1)'(mag[2]);
  end

  assign en = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= sv_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= nx_d;
      ny_q <= mag[1];
      nz_q <= nz_d;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({nz_q, ny_q, nx_q});

endmodule

[rtl/core/hsn_checker.sv]
// Port-level checks for height_to_surface_normal, bound to the top level.
// Depends on hsn_pkg.
module hsn_checker #(
  parameter int FRACTION_BITS = hsn_pkg::FRACTION_BITS_DEF,
  localparam int OUT_W = ((3 * FRACTION_BITS + 2 + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int F = FRACTION_BITS;

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // input side only waits on a stalled full output register
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");

  // magnitudes saturate, so the most negative code never appears
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[F:0] != {1'b1, {F{1'b0}}}
                   && m_axis_tdata[3*F+1:2*F+1] != {1'b1, {F{1'b0}}})
    else $error("component beyond saturation limit");

  // nothing comes out straight after reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind height_to_surface_normal hsn_checker #(.FRACTION_BITS(FRACTION_BITS)) u_hsn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/height_to_surface_normal_tb.sv]
// Self-checking testbench for height_to_surface_normal: streams height triples,
// predicts each unit normal and checks it against the m_axis output.
// Depends on hsn_pkg and the height_to_surface_normal RTL.
module height_to_surface_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB      = hsn_pkg::FRACTION_BITS_DEF;
  localparam int LATENCY = 3 * FB + 9;
  localparam int WD_MAX  = 4000;       // idle cycles before giving up

  typedef struct packed {
    logic [15:0] nz;
    logic [14:0] ny;
    logic [15:0] nx;
  } normal_t;

  // Expected normals in request order, plus the step the block currently uses.
  class normal_scoreboard;
    normal_t            pending[$];
    logic [hsn_pkg::STEP_BITS-1:0] step_len = hsn_pkg::STEP_RESET;
    int                 fails = 0;
    int                 checked = 0;

    // Rounded, saturated magnitude of m * 2^FB / sqrt(s), by exact comparison.
    function logic [15:0] unit_mag(logic [63:0] m, logic [63:0] s);
      logic [127:0] rhs, lhs, d;
      logic [31:0]  q, c;
      rhs = (128'(m) * 128'(m) * 128'd4) << (2 * FB);
      q = 0;
      for (int b = FB; b >= 0; b--) begin
        c = q | (32'd1 << b);
        d = 128'(2 * c - 1);
        lhs = d * d * 128'(s);
        if (lhs <= rhs) q = c;
      end
      if (q > (32'd1 << FB) - 1) q = (32'd1 << FB) - 1;
      return q[15:0];
    endfunction

    function normal_t surface_normal(logic [15:0] h, logic [15:0] hx,
                                     logic [15:0] hy);
      logic [63:0] mx, my, e, s;
      logic [15:0] ax, ay, az;
      normal_t     n;
      e  = (step_len == 0) ? 64'd1 : 64'(step_len);   // zero step held at one
      mx = (hx > h) ? 64'(hx - h) : 64'(h - hx);
      my = (hy > h) ? 64'(hy - h) : 64'(h - hy);
      s  = mx * mx + e * e + my * my;
      ax = unit_mag(mx, s);
      az = unit_mag(my, s);
      ay = unit_mag(e, s);
      // normal points against the slope: rising height gives a negative part
      n.nx = (hx > h) ? -ax : ax;
      n.nz = (hy > h) ? -az : az;
      n.ny = ay[14:0];
      return n;
    endfunction

    function void note_request(logic [15:0] h, logic [15:0] hx, logic [15:0] hy);
      pending.insert(pending.size(), surface_normal(h, hx, hy));
    endfunction

    function void check_result(logic [47:0] data);
      normal_t got, want;
      got = data[46:0];
      if (pending.size() == 0) begin
        $error("normal with no request outstanding: %h", data);
        fails++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.nx !== want.nx) begin
        $error("normal_x expected %0d got %0d", $signed(want.nx), $signed(got.nx));
        fails++;
      end
      if (got.ny !== want.ny) begin
        $error("normal_y expected %0d got %0d", want.ny, got.ny);
        fails++;
      end
      if (got.nz !== want.nz) begin
        $error("normal_z expected %0d got %0d", $signed(want.nz), $signed(got.nz));
        fails++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [hsn_pkg::STEP_BITS-1:0] cfg_data_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [47:0]                   s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [47:0]                   m_axis_tdata;

  normal_scoreboard sb = new();
  int send_idle_pct  = 0;   // chance of a gap after each request
  int recv_stall_pct = 0;   // chance of dropping m_axis_tready each cycle
  int hold_cnt       = 0;   // long receiver hold-off, counted down below
  int quiet_cycles   = 0;
  int sent           = 0;
  int cfg_writes     = 0;

  always #5 clk_i = ~clk_i;

  height_to_surface_normal dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // height_here, height_next_x, height_next_y
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // normal_x, normal_y, normal_z, pad
  );

  // Output side: check every accepted normal, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any handshake on any channel, or an active receiver hold-off, resets the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || hold_cnt > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_MAX) begin
      $display("timeout: no handshake for %0d cycles", WD_MAX);
      $display("simulation failed");
      $finish;
    end
  end

  // One height triple; the request is noted once the edge takes it.
  task automatic send_heights(logic [15:0] h, logic [15:0] hx, logic [15:0] hy);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hy, hx, h};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(h, hx, hy);
    sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Let every outstanding normal come back, then the pipe drain fully.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 6) @(posedge clk_i);
  endtask

  task automatic write_step(logic [hsn_pkg::STEP_BITS-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.step_len = v;
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mix of full-range samples, near-flat patches and steep edges.
  task automatic send_random();
    logic [15:0] h, hx, hy;
    h = 16'($urandom);
    case ($urandom_range(3))
      0: begin hx = 16'($urandom); hy = 16'($urandom); end
      1: begin hx = h + 16'($urandom_range(8)) - 16'd4;
               hy = h + 16'($urandom_range(8)) - 16'd4; end
      2: begin hx = h + 16'($urandom_range(512)) - 16'd256;
               hy = h + 16'($urandom_range(512)) - 16'd256; end
      default: begin hx = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                     hy = 16'($urandom); end
    endcase
    send_heights(h, hx, hy);
  endtask

  initial begin
    logic [hsn_pkg::STEP_BITS-1:0] steps[4];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset step of one.
    send_heights(16'd0, 16'd0, 16'd0);                 // flat
    send_heights(16'hFFFF, 16'hFFFF, 16'hFFFF);        // flat, top of range
    send_heights(16'd0, 16'hFFFF, 16'd0);              // steepest rise along x
    send_heights(16'hFFFF, 16'd0, 16'hFFFF);           // steepest fall along x
    send_heights(16'd0, 16'd0, 16'hFFFF);
    send_heights(16'hFFFF, 16'hFFFF, 16'd0);
    send_heights(16'd0, 16'hFFFF, 16'hFFFF);
    send_heights(16'hFFFF, 16'd0, 16'd0);
    send_heights(16'd100, 16'd101, 16'd100);           // unit slope, 45 degrees
    send_heights(16'd100, 16'd99, 16'd101);
    send_heights(16'h5555, 16'hAAAA, 16'h5554);
    send_heights(16'hAAAA, 16'h5555, 16'hAAAB);
    wait_drained();
    write_step(16'd0);                                 // zero step taken as one
    send_heights(16'd10, 16'd11, 16'd9);
    send_heights(16'd0, 16'd0, 16'd0);
    wait_drained();
    write_step(16'hFFFF);
    send_heights(16'd0, 16'hFFFF, 16'hFFFF);
    send_heights(16'hFFFF, 16'd0, 16'd0);
    send_heights(16'd7, 16'd7, 16'd7);
    send_heights(16'd7, 16'd8, 16'd6);
    wait_drained();

    // Random phases; the step changes only with the pipe empty.
    steps = '{16'd1, 16'd256, 16'hFFFF, 16'd3};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      write_step(ph == 3 ? 16'($urandom_range(1, 65535)) : steps[ph]);
      for (int i = 0; i < 400; i++) begin
        if (ph == 0 && i == 150) hold_cnt = 300;   // pipe fills, input stalls
        if (ph == 1 && i == 200) wait_drained();   // sender waits for all results
        send_random();
      end
      wait_drained();
    end

    $display("covered %0d height triples, %0d normals checked, %0d step writes",
             sent, sb.checked, cfg_writes);
    $display("including flat, steepest and zero-step cases, stalls on both sides");
    if (sb.fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

[height_to_surface_normal.f]
rtl/core/hsn_pkg.sv
rtl/core/height_to_surface_normal.sv
rtl/core/hsn_checker.sv
verif/height_to_surface_normal_tb.sv
